>>> design/gnsa_pkg.sv
// ----------------------------------------------------------------------------
// gnsa_pkg
// Shared constants and controller/datapath interface types for the greedy
// nearest slot assigner.
// ----------------------------------------------------------------------------
package gnsa_pkg;

    localparam int MAX_MEMBERS = 64;
    localparam int MAX_SLOTS   = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int POS_W       = 20;
    localparam int PREV_W      = 7;
    localparam int HYST_W      = 16;
    localparam int DIFF_W      = POS_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DIST_W      = PROD_W + 2;
    localparam int BONUS_W     = 2 * HYST_W;
    localparam int MPOS_W      = 3 * POS_W + PREV_W;
    localparam int SPOS_W      = 3 * POS_W;

    localparam logic [1:0] OP_LOAD_MEMBER = 2'd0;
    localparam logic [1:0] OP_LOAD_SLOT   = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    localparam logic [HYST_W-1:0] HYST_RESET = 16'd768;
    localparam logic [PREV_W-1:0] SLOT_NONE  = 7'h7f;

    typedef struct packed {
        logic start;
        logic bonus;
        logic m_clr;
        logic m_inc;
        logic s_clr;
        logic s_inc;
        logic mlat;
        logic sdif;
        logic mx;
        logic my;
        logic mz;
        logic sum;
        logic adj;
        logic cmp;
        logic commit;
        logic o_ld;
    } t_cmd;

    typedef struct packed {
        logic m_end;
        logic s_end;
        logic done_cur;
        logic taken_cur;
        logic found;
        logic mc_zero;
        logic out_last;
        logic out_acc;
    } t_sts;

endpackage

>>> design/gnsa_ram.sv
// ----------------------------------------------------------------------------
// gnsa_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gnsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/gnsa_ctrl.sv
// ----------------------------------------------------------------------------
// gnsa_ctrl
// Sequencer for the greedy matching rounds and the result walk.
// ----------------------------------------------------------------------------
module gnsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_acc,
    input  logic [1:0]    i_operation,
    input  gnsa_pkg::t_sts i_sts,
    output gnsa_pkg::t_cmd o_cmd,
    output logic          o_idle
);

    import gnsa_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_BON   = 18'h00002,
        S_MNEXT = 18'h00004,
        S_MRD   = 18'h00008,
        S_MLAT  = 18'h00010,
        S_SNEXT = 18'h00020,
        S_SRD   = 18'h00040,
        S_SDIF  = 18'h00080,
        S_MX    = 18'h00100,
        S_MY    = 18'h00200,
        S_MZ    = 18'h00400,
        S_SUM   = 18'h00800,
        S_ADJ   = 18'h01000,
        S_CMP   = 18'h02000,
        S_REND  = 18'h04000,
        S_ORD   = 18'h08000,
        S_OLD   = 18'h10000,
        S_OWAIT = 18'h20000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_acc && i_operation == OP_COMPUTE) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_BON;
                end
            end
            S_BON: begin
                o_cmd.bonus = 1'b1;
                n_state     = i_sts.mc_zero ? S_IDLE : S_MNEXT;
            end
            S_MNEXT: begin
                if (i_sts.m_end) begin
                    n_state = S_REND;
                end else if (i_sts.done_cur) begin
                    o_cmd.m_inc = 1'b1;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: n_state = S_MLAT;
            S_MLAT: begin
                o_cmd.mlat  = 1'b1;
                o_cmd.s_clr = 1'b1;
                n_state     = S_SNEXT;
            end
            S_SNEXT: begin
                if (i_sts.s_end) begin
                    o_cmd.m_inc = 1'b1;
                    n_state     = S_MNEXT;
                end else if (i_sts.taken_cur) begin
                    o_cmd.s_inc = 1'b1;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SRD: n_state = S_SDIF;
            S_SDIF: begin
                o_cmd.sdif = 1'b1;
                n_state    = S_MX;
            end
            S_MX: begin
                o_cmd.mx = 1'b1;
                n_state  = S_MY;
            end
            S_MY: begin
                o_cmd.my = 1'b1;
                n_state  = S_MZ;
            end
            S_MZ: begin
                o_cmd.mz = 1'b1;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_ADJ;
            end
            S_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp   = 1'b1;
                o_cmd.s_inc = 1'b1;
                n_state     = S_SNEXT;
            end
            S_REND: begin
                o_cmd.m_clr = 1'b1;
                if (i_sts.found) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_MNEXT;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_ORD: n_state = S_OLD;
            S_OLD: begin
                o_cmd.o_ld = 1'b1;
                n_state    = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_sts.out_acc) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.m_inc = 1'b1;
                        n_state     = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> design/gnsa_dpath.sv
// ----------------------------------------------------------------------------
// gnsa_dpath
// Position stores, shared squaring unit, best pair tracking, assignment
// store and result register.
// ----------------------------------------------------------------------------
module gnsa_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gnsa_pkg::t_cmd                    i_cmd,
    output gnsa_pkg::t_sts                    o_sts,
    input  logic                              i_in_acc,
    input  logic [1:0]                        i_operation,
    input  logic [gnsa_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [gnsa_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [gnsa_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [gnsa_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [gnsa_pkg::PREV_W-1:0] i_previous_slot,
    input  logic [gnsa_pkg::CNT_W-1:0]        i_member_count,
    input  logic [gnsa_pkg::CNT_W-1:0]        i_slot_count,
    input  logic                              i_cfg_we,
    input  logic [gnsa_pkg::HYST_W-1:0]       i_cfg_data,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [gnsa_pkg::IDX_W-1:0]        o_member_index,
    output logic signed [gnsa_pkg::PREV_W-1:0] o_assigned_slot,
    output logic                              o_last
);

    import gnsa_pkg::*;

    logic [HYST_W-1:0]  r_hyst;
    logic [BONUS_W-1:0] r_bonus;
    logic [CNT_W-1:0]   r_mc, r_sc, r_m, r_s;
    logic [MAX_MEMBERS-1:0] r_done;
    logic [MAX_SLOTS-1:0]   r_taken;
    logic signed [POS_W-1:0]  r_mx, r_my, r_mz;
    logic signed [PREV_W-1:0] r_prev;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [PROD_W-1:0]  r_prod;
    logic [DIST_W-1:0]  r_acc, r_dist, r_best;
    logic               r_found;
    logic [IDX_W-1:0]   r_bm, r_bs;
    logic               r_o_valid;
    logic [IDX_W-1:0]   r_o_member;
    logic [PREV_W-1:0]  r_o_slot;
    logic               r_o_last;

    logic [MPOS_W-1:0]  mem_rdata;
    logic [SPOS_W-1:0]  slot_rdata;
    logic [PREV_W-1:0]  map_rdata;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [POS_W-1:0]  sx, sy, sz;
    logic               is_prev;
    logic [DIST_W-1:0]  bonus_ext;

    gnsa_ram #(.WIDTH(MPOS_W), .DEPTH(MAX_MEMBERS)) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (i_in_acc && i_operation == OP_LOAD_MEMBER),
        .i_waddr (i_entry_index),
        .i_wdata ({i_previous_slot, i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (r_m[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    gnsa_ram #(.WIDTH(SPOS_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_in_acc && i_operation == OP_LOAD_SLOT),
        .i_waddr (i_entry_index),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (r_s[IDX_W-1:0]),
        .o_rdata (slot_rdata)
    );

    gnsa_ram #(.WIDTH(PREV_W), .DEPTH(MAX_MEMBERS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && r_found),
        .i_waddr (r_bm),
        .i_wdata ({1'b0, r_bs}),
        .i_raddr (r_m[IDX_W-1:0]),
        .o_rdata (map_rdata)
    );

    assign sx = $signed(slot_rdata[POS_W-1:0]);
    assign sy = $signed(slot_rdata[2*POS_W-1:POS_W]);
    assign sz = $signed(slot_rdata[3*POS_W-1:2*POS_W]);

    always_comb begin
        mul_a = r_dx;
        if (i_cmd.bonus) begin
            mul_a = $signed({{(DIFF_W-HYST_W){1'b0}}, r_hyst});
        end else if (i_cmd.my) begin
            mul_a = r_dy;
        end else if (i_cmd.mz) begin
            mul_a = r_dz;
        end
    end

    assign mul_p     = mul_a * mul_a;
    assign is_prev   = (r_prev == $signed({1'b0, r_s[IDX_W-1:0]}));
    assign bonus_ext = {{(DIST_W-BONUS_W){1'b0}}, r_bonus};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst    <= HYST_RESET;
            r_done    <= '0;
            r_taken   <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
            r_m       <= '0;
            r_s       <= '0;
            r_mc      <= '0;
            r_sc      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_hyst <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_mc    <= (i_member_count > CNT_W'(MAX_MEMBERS)) ?
                           CNT_W'(MAX_MEMBERS) : i_member_count;
                r_sc    <= (i_slot_count > CNT_W'(MAX_SLOTS)) ?
                           CNT_W'(MAX_SLOTS) : i_slot_count;
                r_done  <= '0;
                r_taken <= '0;
                r_found <= 1'b0;
                r_m     <= '0;
            end
            if (i_cmd.m_clr) begin
                r_m <= '0;
            end else if (i_cmd.m_inc) begin
                r_m <= r_m + 1'b1;
            end
            if (i_cmd.s_clr) begin
                r_s <= '0;
            end else if (i_cmd.s_inc) begin
                r_s <= r_s + 1'b1;
            end
            if (i_cmd.cmp && (!r_found || r_dist < r_best)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_done[r_bm]  <= 1'b1;
                r_taken[r_bs] <= 1'b1;
                r_found       <= 1'b0;
            end
            if (i_cmd.o_ld) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.bonus) begin
            r_bonus <= BONUS_W'($unsigned(mul_p));
        end
        if (i_cmd.mlat) begin
            r_mx   <= $signed(mem_rdata[POS_W-1:0]);
            r_my   <= $signed(mem_rdata[2*POS_W-1:POS_W]);
            r_mz   <= $signed(mem_rdata[3*POS_W-1:2*POS_W]);
            r_prev <= $signed(mem_rdata[MPOS_W-1:3*POS_W]);
        end
        if (i_cmd.sdif) begin
            r_dx <= DIFF_W'(r_mx) - DIFF_W'(sx);
            r_dy <= DIFF_W'(r_my) - DIFF_W'(sy);
            r_dz <= DIFF_W'(r_mz) - DIFF_W'(sz);
        end
        if (i_cmd.mx || i_cmd.my || i_cmd.mz) begin
            r_prod <= $unsigned(mul_p);
        end
        if (i_cmd.my) begin
            r_acc <= {2'b00, r_prod};
        end else if (i_cmd.mz || i_cmd.sum) begin
            r_acc <= r_acc + {2'b00, r_prod};
        end
        if (i_cmd.adj) begin
            if (is_prev) begin
                r_dist <= (r_acc > bonus_ext) ? r_acc - bonus_ext : '0;
            end else begin
                r_dist <= r_acc;
            end
        end
        if (i_cmd.cmp && (!r_found || r_dist < r_best)) begin
            r_best <= r_dist;
            r_bm   <= r_m[IDX_W-1:0];
            r_bs   <= r_s[IDX_W-1:0];
        end
        if (i_cmd.o_ld) begin
            r_o_member <= r_m[IDX_W-1:0];
            r_o_slot   <= r_done[r_m[IDX_W-1:0]] ? map_rdata : SLOT_NONE;
            r_o_last   <= (r_m == r_mc - 1'b1);
        end
    end

    assign o_sts.m_end     = (r_m == r_mc);
    assign o_sts.s_end     = (r_s == r_sc);
    assign o_sts.done_cur  = r_done[r_m[IDX_W-1:0]];
    assign o_sts.taken_cur = r_taken[r_s[IDX_W-1:0]];
    assign o_sts.found     = r_found;
    assign o_sts.mc_zero   = (r_mc == '0);
    assign o_sts.out_last  = r_o_last;
    assign o_sts.out_acc   = r_o_valid && !i_stall;

    assign o_valid         = r_o_valid;
    assign o_member_index  = r_o_member;
    assign o_assigned_slot = $signed(r_o_slot);
    assign o_last          = r_o_last;

endmodule

>>> design/greedy_nearest_slot_assigner_unit.sv
// a load writes its store on accept; a compute squares hysteresis into the bonus, then runs rounds
// each round: free member and slot pairs get difference, squares, sum, bonus, compare; best one commits
// results: one beat per member, read from the registered assignment store, held while output stalls
// one item at a time; stall is high from compute accept to the last beat, or to the bonus with no members
// reset: synchronous active low, hysteresis back to 768, run flags cleared
// ----------------------------------------------------------------------------
// greedy_nearest_slot_assigner_unit
// Top level: greedy nearest matching of members to slots.
// ----------------------------------------------------------------------------
module greedy_nearest_slot_assigner_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_operation,
    input  logic [gnsa_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [gnsa_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [gnsa_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [gnsa_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [gnsa_pkg::PREV_W-1:0] i_previous_slot,
    input  logic [gnsa_pkg::CNT_W-1:0]         i_member_count,
    input  logic [gnsa_pkg::CNT_W-1:0]         i_slot_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gnsa_pkg::HYST_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [gnsa_pkg::IDX_W-1:0]         o_member_index,
    output logic signed [gnsa_pkg::PREV_W-1:0] o_assigned_slot,
    output logic                               o_last
);

    import gnsa_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic in_acc;

    assign o_stall     = !idle;
    assign in_acc      = i_valid && idle;
    assign o_cfg_ready = 1'b1;

    gnsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (in_acc),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_idle      (idle)
    );

    gnsa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_acc        (in_acc),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_previous_slot (i_previous_slot),
        .i_member_count  (i_member_count),
        .i_slot_count    (i_slot_count),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_member_index  (o_member_index),
        .o_assigned_slot (o_assigned_slot),
        .o_last          (o_last)
    );

`ifndef ASSERT_OFF
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result beat while input side idle");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == OP_COMPUTE) |=> o_stall)
        else $error("compute accepted but block not busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> !o_stall)
        else $error("block not idle after last result beat");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy nearest slot assigner. A directed table
// covers extremes, empty counts, ignored operations, ties and the previous
// slot bonus. Random well-formed load/compute sequences follow, checked
// against an in-bench greedy matcher under several hysteresis settings,
// with random idle and stall on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
    import gnsa_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         FROM_MODEL = -2;

    typedef struct {
        logic [1:0]               op;
        logic [IDX_W-1:0]         idx;
        logic signed [POS_W-1:0]  x, y, z;
        logic signed [PREV_W-1:0] prev;
        logic [CNT_W-1:0]         mc, sc;
        int                       fixed_slot;
    } t_row;

    typedef struct {
        logic [IDX_W-1:0]         member;
        logic signed [PREV_W-1:0] slot;
        logic                     last;
    } t_assign;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_operation = '0;
    logic [IDX_W-1:0]         i_entry_index = '0;
    logic signed [POS_W-1:0]  i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [PREV_W-1:0] i_previous_slot = '0;
    logic [CNT_W-1:0]         i_member_count = '0, i_slot_count = '0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [HYST_W-1:0]        i_cfg_data = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [IDX_W-1:0]         o_member_index;
    logic signed [PREV_W-1:0] o_assigned_slot;
    logic                     o_last;

    greedy_nearest_slot_assigner_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [POS_W-1:0]  member_xyz [MAX_MEMBERS][3];
    logic signed [PREV_W-1:0] member_prev [MAX_MEMBERS];
    logic signed [POS_W-1:0]  slot_xyz [MAX_SLOTS][3];
    bit                       member_loaded [MAX_MEMBERS];
    bit                       slot_loaded [MAX_SLOTS];
    logic [HYST_W-1:0]        hyst = HYST_RESET;

    t_assign pending_assign[$];
    t_row    dir_tab[$];
    int      errors = 0, items = 0, beats = 0, computes = 0;
    int      send_idle_pct = 0, stall_pct = 0;
    int      hold_left = 0;
    bit      held = 0;

    function automatic t_row mk(logic [1:0] op, int idx, int x, int y, int z, int prev,
                                int mc, int sc, int fixed_slot);
        t_row r;
        r.op = op; r.idx = IDX_W'(idx);
        r.x = POS_W'(x); r.y = POS_W'(y); r.z = POS_W'(z); r.prev = PREV_W'(prev);
        r.mc = CNT_W'(mc); r.sc = CNT_W'(sc); r.fixed_slot = fixed_slot;
        return r;
    endfunction

    task automatic add_row(t_row r);
        dir_tab = {dir_tab, r};
    endtask

    function automatic longint unsigned pair_dist(int m, int s);
        longint unsigned acc;
        longint d;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            d = longint'(member_xyz[m][k]) - longint'(slot_xyz[s][k]);
            acc += longint'(d * d);
        end
        return acc;
    endfunction

    // greedy matching of the first members to the first slots
    task automatic predict_assignment(t_row r);
        int mc, sc, bm, bs;
        bit found;
        bit done_m [MAX_MEMBERS];
        bit taken_s [MAX_SLOTS];
        int amap [MAX_MEMBERS];
        longint unsigned best, d, bonus;
        t_assign a;
        mc = (int'(r.mc) > MAX_MEMBERS) ? MAX_MEMBERS : int'(r.mc);
        sc = (int'(r.sc) > MAX_SLOTS) ? MAX_SLOTS : int'(r.sc);
        bonus = longint'(hyst) * longint'(hyst);
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            done_m[i] = 0; taken_s[i] = 0; amap[i] = -1;
        end
        forever begin
            found = 0; best = 0; bm = 0; bs = 0;
            for (int m = 0; m < mc; m++) begin
                if (done_m[m]) continue;
                for (int s = 0; s < sc; s++) begin
                    if (taken_s[s]) continue;
                    d = pair_dist(m, s);
                    if (int'(member_prev[m]) == s) d = (d > bonus) ? d - bonus : 0;
                    if (!found || d < best) begin
                        found = 1; best = d; bm = m; bs = s;
                    end
                end
            end
            if (!found) break;
            done_m[bm] = 1; taken_s[bs] = 1; amap[bm] = bs;
        end
        for (int m = 0; m < mc; m++) begin
            a.member = IDX_W'(m);
            a.slot = PREV_W'((r.fixed_slot == FROM_MODEL) ? amap[m] : r.fixed_slot);
            a.last = (m == mc - 1);
            pending_assign = {pending_assign, a};
        end
    endtask

    task automatic apply_item(t_row r);
        case (r.op)
            OP_LOAD_MEMBER: begin
                member_xyz[r.idx][0] = r.x; member_xyz[r.idx][1] = r.y;
                member_xyz[r.idx][2] = r.z; member_prev[r.idx] = r.prev;
                member_loaded[r.idx] = 1;
            end
            OP_LOAD_SLOT: begin
                slot_xyz[r.idx][0] = r.x; slot_xyz[r.idx][1] = r.y;
                slot_xyz[r.idx][2] = r.z; slot_loaded[r.idx] = 1;
            end
            OP_COMPUTE: begin
                computes++;
                predict_assignment(r);
            end
            default: ;
        endcase
    endtask

    task automatic send(t_row r);
        int gap;
        i_valid <= 1'b1;
        i_operation <= r.op; i_entry_index <= r.idx;
        i_pos_x <= r.x; i_pos_y <= r.y; i_pos_z <= r.z;
        i_previous_slot <= r.prev; i_member_count <= r.mc; i_slot_count <= r.sc;
        do @(posedge i_clk); while (o_stall);
        items++;
        apply_item(r);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_hyst(logic [HYST_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_assign.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        hyst = value;
    endtask

    function automatic int loaded_prefix(bit is_slot);
        for (int i = 0; i < 64; i++)
            if (!(is_slot ? slot_loaded[i] : member_loaded[i])) return i;
        return 64;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_coord();
        if ($urandom_range(0, 1)) return POS_W'($urandom);
        return POS_W'($urandom_range(0, 8) * 16 - 64);
    endfunction

    function automatic int pick_count(int prefix, int cap);
        if (prefix == 64 && $urandom_range(0, 4) == 0) return $urandom_range(65, 127);
        return $urandom_range(0, (prefix < cap) ? prefix : cap);
    endfunction

    function automatic t_row rand_load(bit is_slot);
        int idx, p;
        p = loaded_prefix(is_slot);
        idx = (p < 64 && $urandom_range(0, 9) < 8) ? p : $urandom_range(0, 63);
        return mk(is_slot ? OP_LOAD_SLOT : OP_LOAD_MEMBER, idx, rand_coord(), rand_coord(),
                  rand_coord(), $urandom_range(0, 64) - 1, $urandom, $urandom, FROM_MODEL);
    endfunction

    // output side: check each beat, random stall, one long hold
    always @(posedge i_clk) begin
        t_assign e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                beats++;
                if (pending_assign.size() == 0) begin
                    $error("unexpected beat member %0d slot %0d", o_member_index,
                           o_assigned_slot);
                    errors++;
                end else begin
                    e = pending_assign.pop_front();
                    if (o_member_index !== e.member) begin
                        $error("member_index exp %0d got %0d", e.member, o_member_index);
                        errors++;
                    end
                    if (o_assigned_slot !== e.slot) begin
                        $error("assigned_slot exp %0d got %0d", e.slot, o_assigned_slot);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (beats >= 40 && !held) begin
                held = 1;
                hold_left = 400;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [HYST_W-1:0] settings [5];
        int nm, ns, cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(OP_LOAD_MEMBER, 0, 524287, -524288, 524287, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_SLOT, 0, -524288, 524287, -524288, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 1, 1, 0));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 5, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 1, 0, -1));
        add_row(mk(OP_IGNORED, 0, 7, 7, 7, 5, 3, 3, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 1, 1, 0));
        add_row(mk(OP_LOAD_MEMBER, 1, 16, 0, 0, 1, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_MEMBER, 2, 0, 0, 0, -1, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_SLOT, 1, 0, 0, 0, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_SLOT, 2, 48, 0, 0, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 3, 3, FROM_MODEL));
        add_row(mk(OP_LOAD_MEMBER, 3, 0, 0, 0, 63, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_SLOT, 3, 0, 0, 0, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 4, 4, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 4, 2, FROM_MODEL));
        add_row(mk(OP_LOAD_MEMBER, 63, -524288, 524287, -524288, -1, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_SLOT, 63, 524287, -524288, 524287, 0, 0, 0, FROM_MODEL));
        add_row(mk(OP_LOAD_MEMBER, 4, 0, 0, 0, 3, 127, 127, FROM_MODEL));
        add_row(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 5, 4, FROM_MODEL));
        foreach (dir_tab[i]) send(dir_tab[i]);

        settings[0] = 16'd0;
        settings[1] = 16'hffff;
        settings[2] = 16'd16;
        settings[3] = HYST_W'($urandom_range(1, 2000));
        settings[4] = HYST_RESET;
        for (int ph = 0; ph < 5; ph++) begin
            write_hyst(settings[ph]);
            cnt = 0;
            while (cnt < 26) begin
                send_idle_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 6 : 0;
                stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 6 : 0;
                nm = $urandom_range(0, 4);
                ns = $urandom_range(0, 4);
                repeat (nm) begin send(rand_load(0)); cnt++; end
                repeat (ns) begin send(rand_load(1)); cnt++; end
                if ($urandom_range(0, 9) == 0) begin
                    send(mk(OP_IGNORED, $urandom, rand_coord(), rand_coord(), rand_coord(),
                            $urandom, $urandom, $urandom, FROM_MODEL));
                end
                send(mk(OP_COMPUTE, $urandom, rand_coord(), rand_coord(), rand_coord(),
                        $urandom, pick_count(loaded_prefix(0), 10),
                        pick_count(loaded_prefix(1), 10), FROM_MODEL));
                cnt++;
            end
        end

        // fill every remaining entry, then saturate the counts
        send_idle_pct = 6;
        stall_pct = 6;
        for (int i = 0; i < 64; i++) begin
            if (!member_loaded[i]) send(mk(OP_LOAD_MEMBER, i, rand_coord(), rand_coord(),
                                           rand_coord(), $urandom_range(0, 64) - 1,
                                           0, 0, FROM_MODEL));
            if (!slot_loaded[i]) send(mk(OP_LOAD_SLOT, i, rand_coord(), rand_coord(),
                                         rand_coord(), 0, 0, 0, FROM_MODEL));
        end
        send(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 127, 3, FROM_MODEL));
        send(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 5, 127, FROM_MODEL));
        send(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 100, 20, FROM_MODEL));
        send(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 64, 0, -1));
        i_valid <= 1'b0;

        while (pending_assign.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("run covered %0d input beats, %0d computes, %0d result beats",
                 items, computes, beats);
        $display("five hysteresis settings including zero and full scale");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/gnsa_pkg.sv
design/gnsa_ram.sv
design/gnsa_ctrl.sv
design/gnsa_dpath.sv
design/greedy_nearest_slot_assigner_unit.sv
bench/tb_top.sv
